// ===== design/bmse_pkg.sv =====
// Shared constants for the block mean squared error unit.
// No dependencies; imported by every module of the block.
package bmse_pkg;

  // Fixed widths of the result fields.
  localparam int MEAN_W  = 32;
  localparam int COUNT_W = 13;

  // Depth of the queue of finished block sums between the front and the divider.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Divider state codes.
  localparam logic [1:0] DIV_IDLE = 2'd0;
  localparam logic [1:0] DIV_RUN  = 2'd1;
  localparam logic [1:0] DIV_DONE = 2'd2;

endpackage

// ===== design/bmse_front.sv =====
// Front end: takes sample pairs, squares the differences and accumulates per block.
// Depends on bmse_pkg for the queue depth; pushes one record per block.
module bmse_front
  import bmse_pkg::*;
#(
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_ELEMENTS = 4096,
  parameter int SUM_W        = 44,
  parameter int CNT_W        = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample_a,
  input  logic [SAMPLE_BITS-1:0] sample_b,
  input  logic                   last_element,
  input  logic [QUEUE_CNT_W-1:0] q_count,
  output logic                   push,
  output logic [SUM_W-1:0]       push_sum,
  output logic [CNT_W-1:0]       push_count,
  output logic                   push_overflow
);

  logic                    s1_valid;
  logic                    s1_last;
  logic [SAMPLE_BITS-1:0]  s1_mag;
  logic [SUM_W-1:0]        square_sum;
  logic [CNT_W-1:0]        pair_count;
  logic                    overflow_seen;

  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]        diff_abs;
  logic [2*SAMPLE_BITS-1:0]    square;
  logic                        full;
  logic [SUM_W-1:0]            square_sum_next;
  logic [CNT_W-1:0]            pair_count_next;
  logic                        overflow_next;
  logic [QUEUE_CNT_W:0]        queue_claimed;

  // A new word is taken only if its block record is sure to find room in the queue.
  assign queue_claimed = {1'b0, q_count} + {{QUEUE_CNT_W{1'b0}}, (s1_valid & s1_last)};
  assign in_ready      = (queue_claimed < (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));

  // Difference magnitude of the incoming pair, sign-extended by one bit.
  always_comb begin
    diff     = $signed({sample_a[SAMPLE_BITS-1], sample_a})
             - $signed({sample_b[SAMPLE_BITS-1], sample_b});
    diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-diff) : diff;
  end

  // Stage one holds the magnitude and the last flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= in_valid & in_ready;
      s1_last  <= last_element;
    end
    s1_mag <= diff_abs[SAMPLE_BITS-1:0];
  end

  // Stage two squares and accumulates, saturating at the maximum block size.
  always_comb begin
    square          = s1_mag * s1_mag;
    full            = (pair_count >= CNT_W'(MAX_ELEMENTS));
    square_sum_next = square_sum;
    pair_count_next = pair_count;
    overflow_next   = overflow_seen;
    if (full) begin
      overflow_next = 1'b1;
    end else begin
      square_sum_next = square_sum + SUM_W'(square);
      pair_count_next = pair_count + CNT_W'(1);
    end
  end

  assign push          = s1_valid & s1_last;
  assign push_sum      = square_sum_next;
  assign push_count    = pair_count_next;
  assign push_overflow = overflow_next;

  // Running block state clears once its record has been pushed.
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      pair_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (s1_valid) begin
      if (s1_last) begin
        square_sum    <= '0;
        pair_count    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        square_sum    <= square_sum_next;
        pair_count    <= pair_count_next;
        overflow_seen <= overflow_next;
      end
    end
  end

endmodule

// ===== design/bmse_queue.sv =====
// Short queue of block records between the accumulator and the divider.
// Depends on bmse_pkg for its depth; the writer never pushes when full.
module bmse_queue
  import bmse_pkg::*;
#(
  parameter int WIDTH = 58
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic                   q_valid,
  output logic [WIDTH-1:0]       q_data,
  output logic [QUEUE_CNT_W-1:0] q_count
);

  logic [WIDTH-1:0]       entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;

  assign q_valid = (q_count != '0);
  assign q_data  = entries[rd_ptr];

  // Pointers wrap naturally at a power-of-two depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        q_count <= q_count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        q_count <= q_count - QUEUE_CNT_W'(1);
      end
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/bmse_div.sv =====
// Back end: restoring divider that forms sum / count, one quotient bit per cycle.
// Depends on bmse_pkg for state codes and result widths; drives the output register.
module bmse_div
  import bmse_pkg::*;
#(
  parameter int SUM_W = 44,
  parameter int CNT_W = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  logic [SUM_W-1:0]   q_sum,
  input  logic [CNT_W-1:0]   q_count,
  input  logic               q_overflow,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MEAN_W-1:0]  mean_error,
  output logic [COUNT_W-1:0] element_count,
  output logic               overflow
);

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
  localparam int QW     = (SUM_W > MEAN_W) ? SUM_W : MEAN_W;
  localparam int CW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [1:0]       state;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] divisor;
  logic             ovf;

  logic [CNT_W:0]   trial;
  logic             fits;
  logic [CNT_W:0]   trial_diff;
  logic             load_out;
  logic [QW-1:0]    quo_ext;
  logic [CW-1:0]    cnt_ext;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial      = {rem, quo[SUM_W-1]};
    fits       = (trial >= {1'b0, divisor});
    trial_diff = trial - {1'b0, divisor};
  end

  assign pop      = (state == DIV_IDLE) && q_valid;
  assign load_out = (state == DIV_DONE) && (!out_valid || out_ready);
  assign quo_ext  = QW'(quo);
  assign cnt_ext  = CW'(divisor);

  // Divider sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      step  <= '0;
    end else begin
      case (state)
        DIV_IDLE: begin
          if (q_valid) begin
            state <= DIV_RUN;
            step  <= '0;
          end
        end
        DIV_RUN: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (load_out) begin
            state <= DIV_IDLE;
          end
        end
        default: begin
          state <= DIV_IDLE;
        end
      endcase
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (pop) begin
      quo     <= q_sum;
      rem     <= '0;
      divisor <= q_count;
      ovf     <= q_overflow;
    end else if (state == DIV_RUN) begin
      rem <= fits ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  // Output register holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mean_error    <= quo_ext[MEAN_W-1:0];
      element_count <= cnt_ext[COUNT_W-1:0];
      overflow      <= ovf;
    end
  end

endmodule

// ===== design/block_mean_squared_error_unit.sv =====
// Top level of the block mean squared error unit.
// Depends on bmse_pkg and instantiates bmse_front, bmse_queue and bmse_div.
//
// Usage:
// The input channel (in_valid/in_ready) carries one word per sample pair:
// sample_a, sample_b and last_element, which marks the final pair of a block.
// The output channel (out_valid/out_ready) carries one word per block:
// mean_error (sum of squared differences over the count, truncated),
// element_count and a sticky overflow flag for blocks longer than
// MAX_ELEMENTS pairs; extra pairs are dropped from sum and count.
// Throughput: one pair per cycle inside a block while in_ready is high. Each
// block needs one pass of the bit-serial divider, which runs while the next
// block accumulates; a two-entry queue of block sums sits between them, so
// blocks shorter than the divider pass throttle the input.
// When the receiver stalls, the result is held in the output register, the
// queue fills and in_ready drops once no room is left for another block.
// Reset clears the running sum, count, queue and output valid.
module block_mean_squared_error_unit
  import bmse_pkg::*;
#(
  parameter int MAX_ELEMENTS = 4096,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample_a,
  input  logic [SAMPLE_BITS-1:0] sample_b,
  input  logic                   last_element,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MEAN_W-1:0]      mean_error,
  output logic [COUNT_W-1:0]     element_count,
  output logic                   overflow
);

  localparam int SUM_FULL_W = 2 * SAMPLE_BITS + $clog2(MAX_ELEMENTS);
  localparam int SUM_W      = (SUM_FULL_W > 64) ? 64 : SUM_FULL_W;
  localparam int CNT_W      = $clog2(MAX_ELEMENTS + 1);
  localparam int REC_W      = SUM_W + CNT_W + 1;

  logic                   push;
  logic [SUM_W-1:0]       push_sum;
  logic [CNT_W-1:0]       push_count;
  logic                   push_overflow;
  logic                   pop;
  logic                   q_valid;
  logic [REC_W-1:0]       q_data;
  logic [QUEUE_CNT_W-1:0] q_count;

  // Accumulator front end.
  bmse_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_a      (sample_a),
    .sample_b      (sample_b),
    .last_element  (last_element),
    .q_count       (q_count),
    .push          (push),
    .push_sum      (push_sum),
    .push_count    (push_count),
    .push_overflow (push_overflow)
  );

  // Queue of finished block records.
  bmse_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_count, push_overflow}),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_count   (q_count)
  );

  // Divider back end with the output register.
  bmse_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_sum         (q_data[REC_W-1 -: SUM_W]),
    .q_count       (q_data[CNT_W:1]),
    .q_overflow    (q_data[0]),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mean_error    (mean_error),
    .element_count (element_count),
    .overflow      (overflow)
  );

endmodule
